/* rtl/tfre_pkg.sv */
// ----------------------------------------------------------------------------
// tfre_pkg
// Shared types, widths and helpers for the trajectory feed-rate exporter.
// ----------------------------------------------------------------------------
package tfre_pkg;

  // Position width of a sample coordinate (16..48)
  localparam int POS_WIDTH  = 32;
  localparam int FIELD_W    = 32;
  localparam int PAD_W      = (POS_WIDTH > FIELD_W) ? POS_WIDTH : FIELD_W;

  // Distance arithmetic widths
  localparam int MAG_W      = POS_WIDTH;          // |a - b|
  localparam int SQ_W       = 2 * MAG_W;          // one square
  localparam int SUM_W      = SQ_W + 2;           // sum of three squares
  localparam int FRAC_SH    = 16;                 // Q.8 distance -> Q.16 radicand
  localparam int RAD_W      = SUM_W + FRAC_SH;    // even by construction
  localparam int ROOT_W     = RAD_W / 2;

  // Feed scaling: 60 s/min * 1000 um/mm in Q24.8 = 15360000 = 60000 * 256
  localparam int SCALE_W    = 16;
  localparam logic [SCALE_W-1:0] FEED_SCALE = 16'd60000;
  localparam int PROD_W     = ROOT_W + SCALE_W;

  // Divider widths
  localparam int Q_W        = 32;
  localparam int DEN_W      = 32;
  localparam int HI_W       = PROD_W - Q_W;
  localparam int CMP_W      = (HI_W > DEN_W) ? HI_W : DEN_W;

  localparam logic [31:0] MIN_FEED = 32'd256;

  // Configuration register reset values
  localparam logic [31:0] SAFE_HEIGHT_RST  = 32'd5000;
  localparam logic [31:0] DEFAULT_FEED_RST = 32'd256000;
  localparam logic [31:0] RAPID_RATE_RST   = 32'd1280000;

  typedef enum logic [1:0] {
    REG_SAFE_HEIGHT  = 2'd0,
    REG_DEFAULT_FEED = 2'd1,
    REG_RAPID_RATE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_RAPID_Z     = 2'd0,
    KIND_RAPID_XY    = 2'd1,
    KIND_LINEAR      = 2'd2,
    KIND_LINEAR_FEED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    EMIT_RETRACT = 2'd0,
    EMIT_XY      = 2'd1,
    EMIT_DOWN    = 2'd2,
    EMIT_LINEAR  = 2'd3
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIRST_RETRACT,
    ST_EMIT_XY,
    ST_EMIT_DOWN,
    ST_END_RETRACT,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_SCALE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FEED,
    ST_EMIT_LINEAR
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  latch_in;
    logic  sq_step;
    axis_t sq_axis;
    logic  sqrt_start;
    logic  scale;
    logic  div_start;
    logic  feed_eval;
    logic  emit;
    emit_t emit_sel;
    logic  emit_last;
    logic  commit_first;
    logic  commit_end;
    logic  commit_linear;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_end;
    logic started;
    logic dt_pos;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } stat_t;

  // Low POS_WIDTH bits of a field, as two's complement
  function automatic logic signed [POS_WIDTH-1:0] pos_of(logic [FIELD_W-1:0] f);
    logic [PAD_W-1:0] w;
    w = PAD_W'(f);
    return w[POS_WIDTH-1:0];
  endfunction

  // Position back to a 32-bit field, sign-extended then truncated
  function automatic logic [FIELD_W-1:0] to_field(logic signed [POS_WIDTH-1:0] p);
    logic signed [PAD_W-1:0] w;
    w = PAD_W'(p);
    return w[FIELD_W-1:0];
  endfunction

endpackage

/* rtl/tfre_isqrt.sv */
// ----------------------------------------------------------------------------
// tfre_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module tfre_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tfre_pkg::RAD_W-1:0]    radicand,
  output logic [tfre_pkg::ROOT_W-1:0]   root,
  output logic                          done
);

  localparam int REM_W = tfre_pkg::ROOT_W + 2;
  localparam int CNT_W = $clog2(tfre_pkg::ROOT_W + 1);

  logic [tfre_pkg::RAD_W-1:0] rad;
  logic [REM_W-1:0]           rem;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;

  logic [REM_W+1:0] rem_t;
  logic [REM_W+1:0] trial;
  logic             ge;

  always_comb begin
    rem_t = {rem, rad[tfre_pkg::RAD_W-1 -: 2]};
    trial = (REM_W + 2)'({root, 2'b01});
    ge    = (rem_t >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(tfre_pkg::ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
      root <= {root[tfre_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

/* rtl/tfre_div.sv */
// ----------------------------------------------------------------------------
// tfre_div
// Restoring divider with 32-bit saturated quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module tfre_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tfre_pkg::PROD_W-1:0]  num,
  input  logic [tfre_pkg::DEN_W-1:0]   den,
  output logic [tfre_pkg::Q_W-1:0]     quot,
  output logic                         done
);

  localparam int CNT_W = $clog2(tfre_pkg::Q_W + 1);

  logic [tfre_pkg::Q_W-1:0]   q;
  logic [tfre_pkg::DEN_W-1:0] rem;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic                       sat;

  logic [tfre_pkg::HI_W-1:0]  hi;
  logic                       over;
  logic [tfre_pkg::DEN_W:0]   rem_t;
  logic                       ge;

  always_comb begin
    hi    = num[tfre_pkg::PROD_W-1:tfre_pkg::Q_W];
    // quotient reaches 2^32 exactly when the upper part is not below den
    over  = (tfre_pkg::CMP_W'(hi) >= tfre_pkg::CMP_W'(den));
    rem_t = {rem, q[tfre_pkg::Q_W-1]};
    ge    = (rem_t >= {1'b0, den});
    quot  = sat ? '1 : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !over;
        done <= over;
        cnt  <= CNT_W'(tfre_pkg::Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat <= over;
      rem <= tfre_pkg::DEN_W'(hi);
      q   <= num[tfre_pkg::Q_W-1:0];
    end else if (busy) begin
      rem <= ge ? tfre_pkg::DEN_W'(rem_t - {1'b0, den}) : rem_t[tfre_pkg::DEN_W-1:0];
      q   <= {q[tfre_pkg::Q_W-2:0], ge};
    end
  end

endmodule

/* rtl/tfre_dp.sv */
// ----------------------------------------------------------------------------
// tfre_dp
// Datapath: config registers, trajectory state, distance and feed
// arithmetic, and the output register.
// ----------------------------------------------------------------------------
module tfre_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [127:0]         s_tdata,
  input  logic                 s_tuser,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [31:0]          cfg_data,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  output logic [127:0]         m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast,
  input  tfre_pkg::cmd_t       cmd,
  output tfre_pkg::stat_t      stat
);

  localparam int P = tfre_pkg::POS_WIDTH;

  // Configuration
  logic [31:0] safe_height;
  logic [31:0] default_feed;
  logic [31:0] rapid_rate;

  // Trajectory state
  logic signed [P-1:0] prev_x, prev_y, prev_z;
  logic [31:0]         prev_time;
  logic [31:0]         last_feed;
  logic                started;

  // Latched item
  logic                is_end;
  logic signed [P-1:0] cur_x, cur_y, cur_z;
  logic [31:0]         cur_t;

  // Arithmetic registers
  logic [tfre_pkg::SUM_W-1:0]  sum_sq;
  logic [tfre_pkg::PROD_W-1:0] prod;
  logic [31:0]                 feed_val;
  logic                        attach;

  logic [tfre_pkg::ROOT_W-1:0] root;
  logic [tfre_pkg::Q_W-1:0]    quot;
  logic                        sqrt_done;
  logic                        div_done;

  logic [31:0]                 dt;
  logic                        dt_pos;
  logic signed [P-1:0]         cur_sel, prev_sel;
  logic signed [P:0]           dsel;
  logic [P-1:0]                mag;
  logic [tfre_pkg::SQ_W-1:0]   sq;
  logic [31:0]                 raw, clamped, feed_c, diff;
  logic [36:0]                 diff20;

  always_comb begin
    dt     = cur_t - prev_time;
    dt_pos = (dt != 32'd0) && !dt[31];

    case (cmd.sq_axis)
      tfre_pkg::AXIS_X: begin cur_sel = cur_x; prev_sel = prev_x; end
      tfre_pkg::AXIS_Y: begin cur_sel = cur_y; prev_sel = prev_y; end
      tfre_pkg::AXIS_Z: begin cur_sel = cur_z; prev_sel = prev_z; end
      default:          begin cur_sel = cur_x; prev_sel = prev_x; end
    endcase
    dsel = {cur_sel[P-1], cur_sel} - {prev_sel[P-1], prev_sel};
    mag  = dsel[P] ? P'(-dsel) : P'(dsel);
    sq   = mag * mag;

    // Pick, clamp to rapid rate, floor at one mm/min
    raw     = dt_pos ? quot : default_feed;
    clamped = (raw < rapid_rate) ? raw : rapid_rate;
    feed_c  = (clamped < tfre_pkg::MIN_FEED) ? tfre_pkg::MIN_FEED : clamped;
    diff    = (feed_c > last_feed) ? (feed_c - last_feed) : (last_feed - feed_c);
    diff20  = {1'b0, diff, 4'b0} + {3'b0, diff, 2'b0};

    stat.is_end    = is_end;
    stat.started   = started;
    stat.dt_pos    = dt_pos;
    stat.sqrt_done = sqrt_done;
    stat.div_done  = div_done;
    stat.out_free  = !m_tvalid || m_tready;
  end

  tfre_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand ({sum_sq, {tfre_pkg::FRAC_SH{1'b0}}}),
    .root     (root),
    .done     (sqrt_done)
  );

  tfre_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (prod),
    .den  (dt),
    .quot (quot),
    .done (div_done)
  );

  // Config and trajectory state
  always_ff @(posedge clk) begin
    if (rst) begin
      safe_height  <= tfre_pkg::SAFE_HEIGHT_RST;
      default_feed <= tfre_pkg::DEFAULT_FEED_RST;
      rapid_rate   <= tfre_pkg::RAPID_RATE_RST;
      prev_x       <= '0;
      prev_y       <= '0;
      prev_z       <= '0;
      prev_time    <= '0;
      last_feed    <= '0;
      started      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (tfre_pkg::cfg_reg_t'(cfg_addr))
          tfre_pkg::REG_SAFE_HEIGHT:  safe_height  <= cfg_data;
          tfre_pkg::REG_DEFAULT_FEED: default_feed <= cfg_data;
          tfre_pkg::REG_RAPID_RATE:   rapid_rate   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit_first || cmd.commit_linear) begin
        prev_x    <= cur_x;
        prev_y    <= cur_y;
        prev_z    <= cur_z;
        prev_time <= cur_t;
      end
      if (cmd.commit_first) begin
        last_feed <= '0;
        started   <= 1'b1;
      end
      if (cmd.commit_linear && attach) begin
        last_feed <= feed_val;
      end
      if (cmd.commit_end) begin
        started <= 1'b0;
      end
    end
  end

  // Item latch and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      is_end <= s_tuser;
      cur_x  <= tfre_pkg::pos_of(s_tdata[31:0]);
      cur_y  <= tfre_pkg::pos_of(s_tdata[63:32]);
      cur_z  <= tfre_pkg::pos_of(s_tdata[95:64]);
      cur_t  <= s_tdata[127:96];
    end
    if (cmd.sq_step) begin
      sum_sq <= ((cmd.sq_axis == tfre_pkg::AXIS_X) ? '0 : sum_sq)
              + tfre_pkg::SUM_W'(sq);
    end
    if (cmd.scale) begin
      prod <= tfre_pkg::PROD_W'(root) * tfre_pkg::PROD_W'(tfre_pkg::FEED_SCALE);
    end
    if (cmd.feed_eval) begin
      feed_val <= feed_c;
      attach   <= (diff20 > 37'(feed_c));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tlast <= cmd.emit_last;
      case (cmd.emit_sel)
        tfre_pkg::EMIT_RETRACT: begin
          m_tuser <= tfre_pkg::KIND_RAPID_Z;
          m_tdata <= {32'd0, safe_height, 32'd0, 32'd0};
        end
        tfre_pkg::EMIT_XY: begin
          m_tuser <= tfre_pkg::KIND_RAPID_XY;
          m_tdata <= {32'd0, 32'd0, tfre_pkg::to_field(cur_y), tfre_pkg::to_field(cur_x)};
        end
        tfre_pkg::EMIT_DOWN: begin
          m_tuser <= tfre_pkg::KIND_RAPID_Z;
          m_tdata <= {32'd0, tfre_pkg::to_field(cur_z), 32'd0, 32'd0};
        end
        tfre_pkg::EMIT_LINEAR: begin
          m_tuser <= attach ? tfre_pkg::KIND_LINEAR_FEED : tfre_pkg::KIND_LINEAR;
          m_tdata <= {attach ? feed_val : 32'd0, tfre_pkg::to_field(cur_z),
                      tfre_pkg::to_field(cur_y), tfre_pkg::to_field(cur_x)};
        end
        default: begin
          m_tuser <= tfre_pkg::KIND_RAPID_Z;
          m_tdata <= '0;
        end
      endcase
    end
  end

endmodule

/* rtl/tfre_ctrl.sv */
// ----------------------------------------------------------------------------
// tfre_ctrl
// Sequencer: accepts one item, steps the datapath through the distance and
// feed computation, and issues the result items.
// ----------------------------------------------------------------------------
module tfre_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  tfre_pkg::stat_t  stat,
  output tfre_pkg::cmd_t   cmd
);

  tfre_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfre_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.sq_axis    = tfre_pkg::AXIS_X;
    cmd.emit_sel   = tfre_pkg::EMIT_RETRACT;
    s_tready       = 1'b0;

    case (state)
      tfre_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = tfre_pkg::ST_DECODE;
        end
      end
      tfre_pkg::ST_DECODE: begin
        if (stat.is_end) begin
          state_next = stat.started ? tfre_pkg::ST_END_RETRACT : tfre_pkg::ST_IDLE;
        end else if (!stat.started) begin
          state_next = tfre_pkg::ST_FIRST_RETRACT;
        end else if (stat.dt_pos) begin
          state_next = tfre_pkg::ST_SQ_X;
        end else begin
          state_next = tfre_pkg::ST_FEED;
        end
      end
      tfre_pkg::ST_FIRST_RETRACT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = tfre_pkg::ST_EMIT_XY;
        end
      end
      tfre_pkg::ST_EMIT_XY: begin
        cmd.emit_sel = tfre_pkg::EMIT_XY;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = tfre_pkg::ST_EMIT_DOWN;
        end
      end
      tfre_pkg::ST_EMIT_DOWN: begin
        cmd.emit_sel  = tfre_pkg::EMIT_DOWN;
        cmd.emit_last = 1'b1;
        if (stat.out_free) begin
          cmd.emit         = 1'b1;
          cmd.commit_first = 1'b1;
          state_next       = tfre_pkg::ST_IDLE;
        end
      end
      tfre_pkg::ST_END_RETRACT: begin
        cmd.emit_last = 1'b1;
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.commit_end = 1'b1;
          state_next     = tfre_pkg::ST_IDLE;
        end
      end
      tfre_pkg::ST_SQ_X: begin
        cmd.sq_step = 1'b1;
        state_next  = tfre_pkg::ST_SQ_Y;
      end
      tfre_pkg::ST_SQ_Y: begin
        cmd.sq_step = 1'b1;
        cmd.sq_axis = tfre_pkg::AXIS_Y;
        state_next  = tfre_pkg::ST_SQ_Z;
      end
      tfre_pkg::ST_SQ_Z: begin
        cmd.sq_step = 1'b1;
        cmd.sq_axis = tfre_pkg::AXIS_Z;
        state_next  = tfre_pkg::ST_SQRT_GO;
      end
      tfre_pkg::ST_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_next     = tfre_pkg::ST_SQRT_WAIT;
      end
      tfre_pkg::ST_SQRT_WAIT: begin
        if (stat.sqrt_done) begin
          state_next = tfre_pkg::ST_SCALE;
        end
      end
      tfre_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = tfre_pkg::ST_DIV_GO;
      end
      tfre_pkg::ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = tfre_pkg::ST_DIV_WAIT;
      end
      tfre_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_next = tfre_pkg::ST_FEED;
        end
      end
      tfre_pkg::ST_FEED: begin
        cmd.feed_eval = 1'b1;
        state_next    = tfre_pkg::ST_EMIT_LINEAR;
      end
      tfre_pkg::ST_EMIT_LINEAR: begin
        cmd.emit_sel  = tfre_pkg::EMIT_LINEAR;
        cmd.emit_last = 1'b1;
        if (stat.out_free) begin
          cmd.emit          = 1'b1;
          cmd.commit_linear = 1'b1;
          state_next        = tfre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tfre_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/trajectory_feed_rate_exporter_top.sv */
// ----------------------------------------------------------------------------
// trajectory_feed_rate_exporter_top
// Turns trajectory samples into rapid and linear motion items with feed.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one item per sample or end marker. s_tuser = 1 marks
//   the end of a trajectory; positions are micrometres, timestamp in us.
//   Output stream (m_*): motion items; m_tuser is the move kind, m_tlast is
//   set on the final item caused by one input item.
//   Config port: write safe_height / default_feed / rapid_rate by index
//   while the block is idle; writes take effect on the next clock.
// Processing:
//   The first sample of a trajectory gives three items, each loaded once the
//   output register is free. A later sample with a positive time step
//   passes through squaring of the three axes, a 41-step square root (one
//   root bit per cycle) and a 32-step divide (one quotient bit per cycle)
//   before its item. A non-positive time step skips the squaring, root and
//   divide.
//   One item is worked on at a time; the next is accepted in the cycle after
//   the last result is loaded into the output register.
// Reset clears the trajectory state and loads the register defaults.
// A stalled receiver holds the output register; the sequencer waits before
// each load until the register is free.
// ----------------------------------------------------------------------------
module trajectory_feed_rate_exporter_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64], timestamp[127:96]
  input  logic         s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // target_x[31:0], target_y[63:32], target_z[95:64], feed[127:96]
  output logic [1:0]   m_tuser,   // move_kind
  output logic         m_tlast,   // last
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  tfre_pkg::cmd_t  cmd;
  tfre_pkg::stat_t stat;

  // Sequencer
  tfre_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Arithmetic, state and output register
  tfre_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .cmd     (cmd),
    .stat    (stat)
  );

  // Never overwrite an item the receiver has not taken
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("item loaded while output register busy");

  // An attached feed is never below one mm/min
  a_feed_floor: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tfre_pkg::KIND_LINEAR_FEED) |-> (m_tdata[127:96] >= 32'd256))
    else $error("attached feed below floor");

  // Rapid Z items carry no XY target and no feed
  a_rapid_z_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tfre_pkg::KIND_RAPID_Z) |->
      (m_tdata[63:0] == 64'd0 && m_tdata[127:96] == 32'd0))
    else $error("rapid Z item with stray fields");

  // Accept only when no arithmetic is in flight
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !stat.sqrt_done && !stat.div_done)
    else $error("item accepted during computation");

endmodule

/* tb/trajectory_feed_rate_exporter_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_feed_rate_exporter_top_test
// Self-checking bench for the trajectory feed-rate exporter. Samples and end
// markers go in on the slave stream; every motion item that comes out is
// compared field by field against a bit-exact predictor kept in the bench.
// Directed items cover trajectory start and close, the feed clamps, the 5%
// attach rule, timestamp wrap and register extremes; random trajectories
// with random idling on both streams and register changes between phases
// follow.
// ----------------------------------------------------------------------------
module trajectory_feed_rate_exporter_top_test;

  localparam int RANDOM_ITEMS   = 250;   // productive random items to send
  localparam int SETTLE_CYCLES  = 120;   // covers the feed path of one item
  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int ITEMS_PER_TUNE = 60;    // random items between retunes

  // One predicted motion item
  typedef struct {
    tfre_pkg::kind_t kind;
    logic [31:0]     tx;
    logic [31:0]     ty;
    logic [31:0]     tz;
    logic [31:0]     feed;
    logic            is_last;
  } move_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input starts at a known value
  // --------------------------------------------------------------------------
  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata  = '0;
  logic         s_tuser  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_we   = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [31:0]  cfg_data = '0;

  always #10 clk = ~clk;

  trajectory_feed_rate_exporter_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // pos_x, pos_y, pos_z, timestamp (low to high)
    .s_tuser  (s_tuser),    // action
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // target_x, target_y, target_z, feed (low to high)
    .m_tuser  (m_tuser),    // move_kind
    .m_tlast  (m_tlast),    // last
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and trajectory state
  // --------------------------------------------------------------------------
  logic [31:0] cfg_safe    = tfre_pkg::SAFE_HEIGHT_RST;
  logic [31:0] cfg_default = tfre_pkg::DEFAULT_FEED_RST;
  logic [31:0] cfg_rapid   = tfre_pkg::RAPID_RATE_RST;
  logic [31:0] prev_x      = '0;
  logic [31:0] prev_y      = '0;
  logic [31:0] prev_z      = '0;
  logic [31:0] prev_time   = '0;
  logic [31:0] last_feed   = '0;
  logic        traj_open   = 1'b0;

  move_t pending_moves[$];      // predicted items, oldest first
  int    mismatch_count = 0;
  int    moves_items    = 0;    // input items that caused at least one move
  bit    tx_gaps        = 1'b0; // random gaps between input items
  bit    rx_stalls      = 1'b0; // random m_tready drops

  // --------------------------------------------------------------------------
  // Predictor helpers
  // --------------------------------------------------------------------------
  function automatic move_t make_move(tfre_pkg::kind_t k, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic [31:0] f, logic lst);
    move_t m;
    m.kind    = k;
    m.tx      = x;
    m.ty      = y;
    m.tz      = z;
    m.feed    = f;
    m.is_last = lst;
    return m;
  endfunction

  // |a - b| of two signed 32-bit positions, exact in 64 bits
  function automatic logic [63:0] axis_span(logic [31:0] a, logic [31:0] b);
    logic [63:0] d;
    d = {{32{a[31]}}, a} - {{32{b[31]}}, b};
    return d[63] ? -d : d;
  endfunction

  // floor(sqrt(n)), one root bit per pass from the top
  function automatic logic [63:0] root_floor(logic [127:0] n);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= n) r = c;
    end
    return r[63:0];
  endfunction

  // Work out the motion items one accepted input item causes; queue them
  // and return how many there are.
  function automatic int plan_moves(logic act, logic [31:0] x, logic [31:0] y,
                                    logic [31:0] z, logic [31:0] t);
    logic [31:0]  dtu;
    logic [31:0]  raw;
    logic [31:0]  feed;
    logic [63:0]  ax;
    logic [63:0]  ay;
    logic [63:0]  az;
    logic [127:0] radicand;
    logic [127:0] prod;
    logic [127:0] quo;
    logic [63:0]  change;
    int           n;
    if (act) begin
      // End marker: retract only if a trajectory is open, positions ignored
      if (!traj_open) return 0;
      pending_moves.push_back(make_move(tfre_pkg::KIND_RAPID_Z, '0, '0, cfg_safe,
                                        '0, 1'b1));
      traj_open = 1'b0;
      return 1;
    end
    if (!traj_open) begin
      // Trajectory start: retract, rapid over, rapid down
      pending_moves.push_back(make_move(tfre_pkg::KIND_RAPID_Z, '0, '0, cfg_safe,
                                        '0, 1'b0));
      pending_moves.push_back(make_move(tfre_pkg::KIND_RAPID_XY, x, y, '0, '0, 1'b0));
      pending_moves.push_back(make_move(tfre_pkg::KIND_RAPID_Z, '0, '0, z, '0, 1'b1));
      last_feed = '0;
      traj_open = 1'b1;
      n = 3;
    end else begin
      dtu = t - prev_time;
      if (dtu != 0 && !dtu[31]) begin
        ax       = axis_span(x, prev_x);
        ay       = axis_span(y, prev_y);
        az       = axis_span(z, prev_z);
        radicand = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
        prod     = 128'(root_floor(radicand << 16)) * 128'd60000;
        quo      = prod / 128'(dtu);
        raw      = (quo > 128'h0FFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
      end else begin
        raw = cfg_default;
      end
      feed = (raw < cfg_rapid) ? raw : cfg_rapid;
      if (feed < tfre_pkg::MIN_FEED) feed = tfre_pkg::MIN_FEED;
      change = (feed > last_feed) ? 64'(feed - last_feed) : 64'(last_feed - feed);
      if (change * 64'd20 > 64'(feed)) begin
        pending_moves.push_back(make_move(tfre_pkg::KIND_LINEAR_FEED, x, y, z, feed,
                                          1'b1));
        last_feed = feed;
      end else begin
        pending_moves.push_back(make_move(tfre_pkg::KIND_LINEAR, x, y, z, '0, 1'b1));
      end
      n = 1;
    end
    prev_x    = x;
    prev_y    = y;
    prev_z    = z;
    prev_time = t;
    return n;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one item per call, entered and left on a rising edge. Valid is
  // only lowered here ahead of a gap, so it never drops and rises in one step.
  // --------------------------------------------------------------------------
  task automatic send_item(logic act, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] t);
    int gap;
    int n;
    gap = tx_gaps ? idle_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {t, z, y, x};
    do @(posedge clk); while (!s_tready);
    // Accepted at this edge: predict now, results come cycles later
    n = plan_moves(act, x, y, z, t);
    if (n > 0) moves_items++;
  endtask

  // Hold the sender until every predicted item has come out
  task automatic drain_moves();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_moves.size() != 0) @(posedge clk);
  endtask

  // Drain, then wait out any work on an item that causes no result
  task automatic settle_block();
    drain_moves();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; the block must be idle
  task automatic load_registers(logic [31:0] safe, logic [31:0] dflt, logic [31:0] rapid);
    tfre_pkg::cfg_reg_t idx[3];
    logic [31:0]        val[3];
    idx = '{tfre_pkg::REG_SAFE_HEIGHT, tfre_pkg::REG_DEFAULT_FEED,
            tfre_pkg::REG_RAPID_RATE};
    val = '{safe, dflt, rapid};
    for (int i = 0; i < 3; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we      <= 1'b0;
    cfg_safe    = safe;
    cfg_default = dflt;
    cfg_rapid   = rapid;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: drop m_tready at random while stalls are enabled
  // --------------------------------------------------------------------------
  int rx_hold = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
      rx_hold  = 0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (rx_stalls && $urandom_range(0, 3) == 0) rx_hold = idle_length() + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each accepted item against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    move_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_moves.size() == 0) begin
        flag_mismatch("unexpected item, kind", 32'(m_tuser), '0);
      end else begin
        want = pending_moves.pop_front();
        if (m_tuser != want.kind)        flag_mismatch("move_kind", 32'(m_tuser), 32'(want.kind));
        if (m_tdata[31:0] != want.tx)    flag_mismatch("target_x", m_tdata[31:0], want.tx);
        if (m_tdata[63:32] != want.ty)   flag_mismatch("target_y", m_tdata[63:32], want.ty);
        if (m_tdata[95:64] != want.tz)   flag_mismatch("target_z", m_tdata[95:64], want.tz);
        if (m_tdata[127:96] != want.feed) flag_mismatch("feed", m_tdata[127:96], want.feed);
        if (m_tlast != want.is_last)     flag_mismatch("last", 32'(m_tlast), 32'(want.is_last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run after too many cycles with no handshake
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // First trajectory on reset registers, no idling: stray end before any
  // sample, the three-move start, the 5% attach rule on both sides, the
  // retract, and an end right after an end.
  task automatic test_first_trajectory();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_item(1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hFFFF_FFFF);
    send_item(1'b0, 32'd0, 32'd0, 32'd0, 32'd1000);
    send_item(1'b0, 32'd100, 32'd0, 32'd0, 32'd11000);   // 153600, attached
    send_item(1'b0, 32'd205, 32'd0, 32'd0, 32'd21000);   // just under 5%
    send_item(1'b0, 32'd311, 32'd0, 32'd0, 32'd31000);   // just over 5%
    send_item(1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_item(1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
  endtask

  // Feed corner cases with idling on: clamp to rapid rate, dt of zero and
  // below zero, the minimum feed, saturation on extreme positions and time
  // steps that wrap past the top of the counter.
  task automatic test_feed_cases();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_item(1'b0, -32'sd5, 32'sd7, -32'sd9, 32'hFFFF_FF00);
    send_item(1'b0, 32'd995, 32'sd7, -32'sd9, 32'h0000_02E8);  // wraps, clamps
    send_item(1'b0, 32'd995, 32'd12, -32'sd4, 32'h0000_02E8);  // dt zero
    send_item(1'b0, 32'd995, 32'd12, -32'sd4, 32'h0000_0100);  // dt negative
    send_item(1'b0, 32'd996, 32'd12, -32'sd4, 32'h000F_4340);  // feed floor
    send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h000F_4341);
    send_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h800F_4340);
    send_item(1'b0, 32'd1, 32'd2, 32'd3, 32'h000F_4340);       // most negative dt
    send_item(1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_0000, 32'h0000_FFFF);
  endtask

  // Register extremes: lowest and highest safe height, feeds at full scale,
  // and a rapid rate below the minimum feed.
  task automatic test_register_extremes();
    settle_block();
    load_registers(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0);
    send_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1); // saturates
    send_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1); // dt zero
    send_item(1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
    settle_block();
    load_registers(32'h7FFF_FFFF, tfre_pkg::MIN_FEED, 32'd100);
    send_item(1'b0, 32'd10, 32'd20, 32'd30, 32'd500);
    send_item(1'b0, 32'd5010, 32'd20, 32'd30, 32'd510);
    send_item(1'b0, 32'd5011, 32'd20, 32'd30, 32'd510);
    send_item(1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
  endtask

  // --------------------------------------------------------------------------
  // Random tests
  // --------------------------------------------------------------------------

  // Per-axis step size class, -1 meaning any 32-bit value
  function automatic int pick_span();
    case ($urandom_range(0, 9))
      0:       return 0;
      1, 2:    return 5;
      3, 4:    return 300;
      5, 6:    return 20000;
      7, 8:    return 2000000;
      default: return -1;
    endcase
  endfunction

  function automatic logic [31:0] random_delta(int span);
    if (span < 0) return $urandom;
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [31:0] pick_time_step();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(1, 10);
      2, 3, 4: return $urandom_range(10, 2000);
      5, 6, 7: return $urandom_range(1000, 100000);
      8:       return $urandom_range(1, 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_feed_reg();
    case ($urandom_range(0, 7))
      0:       return tfre_pkg::MIN_FEED;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(256, 5000000);
      default: return $urandom_range(256, 32'hFFFF_FFFF);
    endcase
  endfunction

  function automatic logic [31:0] random_safe_height();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // A well-formed trajectory: start, steady steps at one velocity with the
  // odd irregular step, then usually an end marker
  task automatic run_trajectory();
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] t;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] step;
    int          n_samples;
    n_samples = $urandom_range(1, 12);
    px   = $urandom;
    py   = $urandom;
    pz   = $urandom;
    t    = $urandom;
    vx   = random_delta(pick_span());
    vy   = random_delta(pick_span());
    vz   = random_delta(pick_span());
    step = pick_time_step();
    for (int k = 0; k < n_samples; k++) begin
      if (k > 0) begin
        case ($urandom_range(0, 11))
          0: begin
            // irregular move: jitter position and time
            px = px + random_delta(1000);
            py = py + random_delta(1000);
            t  = t + pick_time_step();
          end
          1: t = t - $urandom_range(0, 5000);   // dt zero or backwards
          2: begin
            px = px + vx + random_delta(2);
            t  = t + step;
          end
          default: begin
            px = px + vx;
            py = py + vy;
            pz = pz + vz;
            t  = t + step;
          end
        endcase
      end
      send_item(1'b0, px, py, pz, t);
    end
    if ($urandom_range(0, 9) != 0) send_item(1'b1, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_random_trajectories();
    int target;
    int next_tune;
    target    = moves_items + RANDOM_ITEMS;
    next_tune = moves_items;
    while (moves_items < target) begin
      if (moves_items >= next_tune) begin
        // New phase: retune registers and pick the idling mix
        settle_block();
        load_registers(random_safe_height(), random_feed_reg(), random_feed_reg());
        tx_gaps   = $urandom_range(0, 2) != 0;
        rx_stalls = $urandom_range(0, 2) != 0;
        next_tune = moves_items + ITEMS_PER_TUNE;
      end
      case ($urandom_range(0, 19))
        0, 1: send_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
        2:    drain_moves();   // hold the sender until the output is empty
        default: run_trajectory();
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed, random, then drain and report
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_first_trajectory();
    test_feed_cases();
    test_register_extremes();
    test_random_trajectories();
    settle_block();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
